### sv/lpem_pkg.sv
// ----------------------------------------------------------------------------
// lpem_pkg
// Shared constants and helpers for the laser peak epipolar matcher.
// ----------------------------------------------------------------------------
package lpem_pkg;

	// Default sizing handed to the top level
	localparam int POINT_DEPTH_DEF = 1024;
	localparam int COORD_BITS_DEF  = 11;

	// Field widths
	localparam int PIX_W       = 8;
	localparam int FUND_W      = 48;
	localparam int OUT_COORD_W = 11;
	localparam int RES_W       = 47;

	// Configuration register map
	localparam int NUM_FUND    = 8;
	localparam int FUND_IDX_W  = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int FUND_11     = 0;
	localparam int FUND_12     = 1;
	localparam int FUND_13     = 2;
	localparam int FUND_21     = 3;
	localparam int FUND_22     = 4;
	localparam int FUND_23     = 5;
	localparam int FUND_31     = 6;
	localparam int FUND_32     = 7;

	// Command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Thresholds and Q8.40 limits
	localparam logic [PIX_W-1:0] PEAK_LIMIT = 8'd200;
	localparam longint MATCH_LIMIT = 64'sd10995116278;
	localparam longint ONE_Q40     = 64'sd1 <<< 40;
	localparam longint Q40_MAX     = (64'sd1 <<< 47) - 64'sd1;
	localparam longint Q40_MIN     = -(64'sd1 <<< 47);

	// Saturate a wide signed value to the signed Q8.40 range
	function automatic logic signed [FUND_W-1:0] sat_q40(input logic signed [63:0] v);
		logic signed [FUND_W-1:0] r;
		if (v > Q40_MAX) begin
			r = FUND_W'(Q40_MAX);
		end else if (v < Q40_MIN) begin
			r = FUND_W'(Q40_MIN);
		end else begin
			r = v[FUND_W-1:0];
		end
		return r;
	endfunction

endpackage

### sv/lpem_ram.sv
// ----------------------------------------------------------------------------
// lpem_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpem_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### sv/laser_peak_epipolar_matcher.sv
// ----------------------------------------------------------------------------
// laser_peak_epipolar_matcher
// Row peak finder on a stereo red-channel stream with epipolar point matching.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries pixel beats (command 0) and
//   drain beats (command 1). Pixel beats are taken one per cycle while no
//   drain is in progress, no result. Each row keeps the brightest left and
//   right column; a peak above 200 stores (column,row) in its point RAM at
//   row end. After end_of_frame, each drain beat reads the next left point,
//   builds the epipolar line in Q8.40, then scans the right point RAM
//   through a pipeline at one point per cycle.
//   in_stall is high for the whole of a drain that gives a result.
//   Output channel (out_valid/out_stall) holds one result in a register; while
//   it waits, pixel beats are still accepted. A finished drain waits for the
//   register to be free. A drain before frame end or past the last point is
//   taken and gives no result.
//   Reset clears counters, peaks, flags and the matrix registers. The point
//   RAMs are not cleared; only entries below the counts are ever read.
//   Configuration (cfg_valid/cfg_ready) is always ready; write only when idle.
// ----------------------------------------------------------------------------
module laser_peak_epipolar_matcher import lpem_pkg::*; #(
	parameter int POINT_DEPTH = POINT_DEPTH_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [PIX_W-1:0]       left_red,
	input  logic [PIX_W-1:0]       right_red,
	input  logic                   end_of_row,
	input  logic                   end_of_frame,
	// Output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_COORD_W-1:0] left_x,
	output logic [OUT_COORD_W-1:0] left_y,
	output logic [OUT_COORD_W-1:0] right_x,
	output logic [OUT_COORD_W-1:0] right_y,
	output logic                   matched,
	output logic [RES_W-1:0]       residual,
	output logic                   store_overflow,
	output logic                   last_point,
	// Configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [FUND_W-1:0]      cfg_data
);

	localparam int ADDR_W = $clog2(POINT_DEPTH);
	localparam int CNT_W  = $clog2(POINT_DEPTH + 1);
	localparam int PT_W   = 2 * COORD_BITS;
	localparam int PROD_W = FUND_W + COORD_BITS + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int EXT_W  = COORD_BITS + OUT_COORD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LMUL,
		S_LSUM,
		S_SCAN,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [FUND_W-1:0] fund_q [NUM_FUND];

	// Row and frame state
	logic [PIX_W-1:0]      lpv_q, rpv_q;
	logic [COORD_BITS-1:0] lpc_q, rpc_q, col_q, row_q;
	logic [CNT_W-1:0]      lcnt_q, rcnt_q, drain_q;
	logic                  ovf_q, closed_q;

	// Scan state
	logic [CNT_W-1:0]      scan_j_q;
	logic                  found_q;
	logic [SUM_W-1:0]      best_q;
	logic [COORD_BITS-1:0] bx_q, by_q;

	// Line computation
	logic signed [PROD_W-1:0] lp_q [6];
	logic [COORD_BITS-1:0]    lx_q, ly_q;
	logic signed [FUND_W-1:0] l1_q, l2_q, l3_q;

	// Scan pipeline
	logic                     v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] p1_s2, p2_s2;
	logic [COORD_BITS-1:0]    x_s2, y_s2, x_s3, y_s3;
	logic [SUM_W-1:0]         a_s3;

	// Output register
	logic                   out_valid_q;
	logic [OUT_COORD_W-1:0] left_x_q, left_y_q, right_x_q, right_y_q;
	logic                   matched_q, ovf_out_q, last_q;
	logic [RES_W-1:0]       residual_q;

	// RAM ports
	logic              l_wr, r_wr;
	logic [ADDR_W-1:0] l_wr_addr, r_wr_addr;
	logic [PT_W-1:0]   l_wr_data, r_wr_data, l_rd_data, r_rd_data;

	// Handshake decode
	logic in_acc, pix_acc, drn_ok, row_end, scan_issue, out_load;

	// Pixel next values
	logic [PIX_W-1:0]      lpv_new, rpv_new;
	logic [COORD_BITS-1:0] lpc_new, rpc_new;
	logic [CNT_W-1:0]      lcnt_eff, rcnt_eff;
	logic                  l_put, r_put;

	// Scan arithmetic
	logic signed [SUM_W-1:0] t_sum;
	logic [SUM_W-1:0]        t_abs;
	logic                    best_match;
	logic [EXT_W-1:0]        ext_lx, ext_ly, ext_bx, ext_by;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign pix_acc   = in_acc && (command == CMD_PIXEL);
	assign drn_ok    = in_acc && (command == CMD_DRAIN) && closed_q && (drain_q < lcnt_q);
	assign row_end   = end_of_row || end_of_frame;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Peak update and store decisions for a pixel beat
	always_comb begin
		lpv_new  = (left_red > lpv_q) ? left_red : lpv_q;
		lpc_new  = (left_red > lpv_q) ? col_q : lpc_q;
		rpv_new  = (right_red > rpv_q) ? right_red : rpv_q;
		rpc_new  = (right_red > rpv_q) ? col_q : rpc_q;
		lcnt_eff = closed_q ? '0 : lcnt_q;
		rcnt_eff = closed_q ? '0 : rcnt_q;
		l_put    = pix_acc && row_end && (lpv_new > PEAK_LIMIT);
		r_put    = pix_acc && row_end && (rpv_new > PEAK_LIMIT);
	end

	assign l_wr      = l_put && (lcnt_eff < CNT_W'(POINT_DEPTH));
	assign r_wr      = r_put && (rcnt_eff < CNT_W'(POINT_DEPTH));
	assign l_wr_addr = lcnt_eff[ADDR_W-1:0];
	assign r_wr_addr = rcnt_eff[ADDR_W-1:0];
	assign l_wr_data = {lpc_new, row_q};
	assign r_wr_data = {rpc_new, row_q};

	lpem_ram #(.WIDTH(PT_W), .DEPTH(POINT_DEPTH)) u_left_ram (
		.clk     (clk),
		.wr_en   (l_wr),
		.wr_addr (l_wr_addr),
		.wr_data (l_wr_data),
		.rd_addr (drain_q[ADDR_W-1:0]),
		.rd_data (l_rd_data)
	);

	lpem_ram #(.WIDTH(PT_W), .DEPTH(POINT_DEPTH)) u_right_ram (
		.clk     (clk),
		.wr_en   (r_wr),
		.wr_addr (r_wr_addr),
		.wr_data (r_wr_data),
		.rd_addr (scan_j_q[ADDR_W-1:0]),
		.rd_data (r_rd_data)
	);

	// Write matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FUND; i++) begin
				fund_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_FUND))) begin
			fund_q[cfg_index[FUND_IDX_W-1:0]] <= cfg_data;
		end
	end

	assign scan_issue = (state_q == S_SCAN) && (scan_j_q < rcnt_q);

	// Residual of the current right point
	always_comb begin
		t_sum = SUM_W'(p1_s2) + SUM_W'(p2_s2) + SUM_W'(l3_q);
		t_abs = t_sum[SUM_W-1] ? SUM_W'(-t_sum) : SUM_W'(t_sum);
	end

	// Line products and scan datapath
	always_ff @(posedge clk) begin
		if (state_q == S_LMUL) begin
			lx_q  <= l_rd_data[PT_W-1:COORD_BITS];
			ly_q  <= l_rd_data[COORD_BITS-1:0];
			lp_q[0] <= PROD_W'(fund_q[FUND_11])
				* PROD_W'($signed({1'b0, l_rd_data[PT_W-1:COORD_BITS]}));
			lp_q[1] <= PROD_W'(fund_q[FUND_12])
				* PROD_W'($signed({1'b0, l_rd_data[COORD_BITS-1:0]}));
			lp_q[2] <= PROD_W'(fund_q[FUND_21])
				* PROD_W'($signed({1'b0, l_rd_data[PT_W-1:COORD_BITS]}));
			lp_q[3] <= PROD_W'(fund_q[FUND_22])
				* PROD_W'($signed({1'b0, l_rd_data[COORD_BITS-1:0]}));
			lp_q[4] <= PROD_W'(fund_q[FUND_31])
				* PROD_W'($signed({1'b0, l_rd_data[PT_W-1:COORD_BITS]}));
			lp_q[5] <= PROD_W'(fund_q[FUND_32])
				* PROD_W'($signed({1'b0, l_rd_data[COORD_BITS-1:0]}));
		end
		if (state_q == S_LSUM) begin
			l1_q <= sat_q40(64'(SUM_W'(lp_q[0]) + SUM_W'(lp_q[1]) + SUM_W'(fund_q[FUND_13])));
			l2_q <= sat_q40(64'(SUM_W'(lp_q[2]) + SUM_W'(lp_q[3]) + SUM_W'(fund_q[FUND_23])));
			l3_q <= sat_q40(64'(SUM_W'(lp_q[4]) + SUM_W'(lp_q[5]) + SUM_W'(ONE_Q40)));
		end
		p1_s2 <= PROD_W'(l1_q) * PROD_W'($signed({1'b0, r_rd_data[PT_W-1:COORD_BITS]}));
		p2_s2 <= PROD_W'(l2_q) * PROD_W'($signed({1'b0, r_rd_data[COORD_BITS-1:0]}));
		x_s2  <= r_rd_data[PT_W-1:COORD_BITS];
		y_s2  <= r_rd_data[COORD_BITS-1:0];
		a_s3  <= t_abs;
		x_s3  <= x_s2;
		y_s3  <= y_s2;
	end

	// Output field formatting
	always_comb begin
		ext_lx     = EXT_W'(lx_q);
		ext_ly     = EXT_W'(ly_q);
		ext_bx     = EXT_W'(bx_q);
		ext_by     = EXT_W'(by_q);
		best_match = found_q && (best_q < SUM_W'(MATCH_LIMIT));
	end

	// Control state, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lpv_q       <= '0;
			rpv_q       <= '0;
			lpc_q       <= '0;
			rpc_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			lcnt_q      <= '0;
			rcnt_q      <= '0;
			drain_q     <= '0;
			ovf_q       <= 1'b0;
			closed_q    <= 1'b0;
			scan_j_q    <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			left_x_q    <= '0;
			left_y_q    <= '0;
			right_x_q   <= '0;
			right_y_q   <= '0;
			matched_q   <= 1'b0;
			residual_q  <= '0;
			ovf_out_q   <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// Load a finished result, else drop a taken one
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Advance the scan pipeline
			v_s1 <= scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			unique case (state_q)
				S_IDLE: begin
					if (pix_acc) begin
						closed_q <= end_of_frame;
						lcnt_q  <= l_wr ? lcnt_eff + CNT_W'(1) : lcnt_eff;
						rcnt_q  <= r_wr ? rcnt_eff + CNT_W'(1) : rcnt_eff;
						ovf_q   <= ((closed_q ? 1'b0 : ovf_q) || (l_put && !l_wr)
							|| (r_put && !r_wr));
						if (closed_q || end_of_frame) begin
							drain_q <= '0;
						end
						if (row_end) begin
							lpv_q <= '0;
							lpc_q <= '0;
							rpv_q <= '0;
							rpc_q <= '0;
							col_q <= '0;
							row_q <= end_of_frame ? '0 : row_q + COORD_BITS'(1);
						end else begin
							lpv_q <= lpv_new;
							lpc_q <= lpc_new;
							rpv_q <= rpv_new;
							rpc_q <= rpc_new;
							col_q <= col_q + COORD_BITS'(1);
						end
					end else if (drn_ok) begin
						state_q <= S_LMUL;
					end
				end
				S_LMUL: begin
					state_q <= S_LSUM;
				end
				S_LSUM: begin
					scan_j_q <= '0;
					found_q  <= 1'b0;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_issue) begin
						scan_j_q <= scan_j_q + CNT_W'(1);
					end
					// Keep the first point of least residual
					if (v_s3 && (!found_q || (a_s3 < best_q))) begin
						best_q  <= a_s3;
						bx_q    <= x_s3;
						by_q    <= y_s3;
						found_q <= 1'b1;
					end
					if (!scan_issue && !v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Load the result once the register is free
					if (out_load) begin
						left_x_q    <= ext_lx[OUT_COORD_W-1:0];
						left_y_q    <= ext_ly[OUT_COORD_W-1:0];
						right_x_q   <= best_match ? ext_bx[OUT_COORD_W-1:0] : '0;
						right_y_q   <= best_match ? ext_by[OUT_COORD_W-1:0] : '0;
						matched_q   <= best_match;
						residual_q  <= (!found_q || (best_q > SUM_W'(Q40_MAX)))
							? RES_W'(Q40_MAX) : best_q[RES_W-1:0];
						ovf_out_q   <= ovf_q;
						last_q      <= (drain_q + CNT_W'(1) == lcnt_q);
						drain_q     <= drain_q + CNT_W'(1);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign left_x         = left_x_q;
	assign left_y         = left_y_q;
	assign right_x        = right_x_q;
	assign right_y        = right_y_q;
	assign matched        = matched_q;
	assign residual       = residual_q;
	assign store_overflow = ovf_out_q;
	assign last_point     = last_q;

endmodule

### sv/lpem_checker.sv
// ----------------------------------------------------------------------------
// lpem_checker
// Port-level assertions for the laser peak epipolar matcher.
// ----------------------------------------------------------------------------
module lpem_checker import lpem_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   command,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [OUT_COORD_W-1:0] left_x,
	input logic [OUT_COORD_W-1:0] right_x,
	input logic [OUT_COORD_W-1:0] right_y,
	input logic                   matched,
	input logic [RES_W-1:0]       residual
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(left_x) && $stable(residual)))
		else $error("result beat changed while stalled");

	// A match always carries a residual under the threshold
	a_match_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && matched) |-> (64'(residual) < MATCH_LIMIT))
		else $error("match reported with large residual");

	// An unmatched result carries a zero right point
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !matched) |-> (right_x == '0 && right_y == '0))
		else $error("unmatched result with non-zero right point");

	// Pixel beats never stall the stream that follows
	a_pixel_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == CMD_PIXEL) |=> !in_stall)
		else $error("stall raised after a pixel beat");

endmodule

bind laser_peak_epipolar_matcher lpem_checker u_lpem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.command   (command),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.left_x    (left_x),
	.right_x   (right_x),
	.right_y   (right_y),
	.matched   (matched),
	.residual  (residual)
);
